@@ design/hbws_pkg.sv @@
// ----------------------------------------------------------------------------
// hbws_pkg
// Types and constants shared by the heartbeat watchdog supervisor files.
// ----------------------------------------------------------------------------
package hbws_pkg;

   localparam int unsigned SEQ_W      = 31;
   localparam int unsigned TICK_W     = 32;
   localparam int unsigned CNT_W      = 32;
   localparam int unsigned TIMEOUT_W  = 31;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 31'd1000;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_MIN   = 31'd1;

   // item kind
   typedef enum logic [1:0] {
      MODE_POST  = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   // stop reason encoding
   typedef enum logic [1:0] {
      REASON_NONE     = 2'd0,
      REASON_BOOT     = 2'd1,
      REASON_DISARMED = 2'd2,
      REASON_TIMEOUT  = 2'd3
   } reason_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic              heartbeat_mode;
      logic [TICK_W-1:0] tick_stamp;
   } req_item_type;

   typedef struct packed {
      logic              done_res;
      logic              stop_fired;
      logic [1:0]        stop_reason;
      logic              motion_permitted;
      logic              timeout_active;
      logic              timeout_latched;
      logic [CNT_W-1:0]  accepted_heartbeats;
      logic [CNT_W-1:0]  timeouts_seen;
      logic [1:0]        last_stop_reason;
   } rsp_item_type;

endpackage

@@ design/hbws_if.sv @@
// ----------------------------------------------------------------------------
// hbws channel interfaces
// Valid/ready channels for requests, results and the timeout register.
// ----------------------------------------------------------------------------
interface hbws_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   mode;
   logic                         heartbeat_mode;
   logic [hbws_pkg::TICK_W-1:0]  tick_stamp;

   modport source (output valid, output mode, output heartbeat_mode, output tick_stamp,
                   input ready);
   modport sink   (input valid, input mode, input heartbeat_mode, input tick_stamp,
                   output ready);
endinterface

interface hbws_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        done_res;
   logic                        stop_fired;
   logic [1:0]                  stop_reason;
   logic                        motion_permitted;
   logic                        timeout_active;
   logic                        timeout_latched;
   logic [hbws_pkg::CNT_W-1:0]  accepted_heartbeats;
   logic [hbws_pkg::CNT_W-1:0]  timeouts_seen;
   logic [1:0]                  last_stop_reason;

   modport source (output valid, output done_res, output stop_fired, output stop_reason,
                   output motion_permitted, output timeout_active,
                   output timeout_latched, output accepted_heartbeats,
                   output timeouts_seen, output last_stop_reason, input ready);
   modport sink   (input valid, input done_res, input stop_fired, input stop_reason,
                   input motion_permitted, input timeout_active,
                   input timeout_latched, input accepted_heartbeats,
                   input timeouts_seen, input last_stop_reason, output ready);
endinterface

interface hbws_csr_if;
   logic                            valid;
   logic                            ready;
   logic [hbws_pkg::TIMEOUT_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ design/hbws_in_stage.sv @@
// ----------------------------------------------------------------------------
// hbws_in_stage
// Input register: captures one request item and holds it until the core
// takes it.
// ----------------------------------------------------------------------------
module hbws_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  hbws_pkg::req_item_type req_item,
   input  logic                   advance,
   output logic                   item_valid,
   output hbws_pkg::req_item_type item
);

   logic                   valid_ff, valid_in;
   hbws_pkg::req_item_type item_ff;
   logic                   take;

   // free slot, or the held item leaves this cycle
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ design/hbws_core.sv @@
// ----------------------------------------------------------------------------
// hbws_core
// Watchdog state, the per-item update logic and the result register.
// ----------------------------------------------------------------------------
module hbws_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   input  hbws_pkg::req_item_type          item,
   output logic                            advance,
   input  logic                            csr_write,
   input  logic [hbws_pkg::TIMEOUT_W-1:0]  csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output hbws_pkg::rsp_item_type          rsp_item
);

   // watchdog state
   logic [hbws_pkg::TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [hbws_pkg::SEQ_W-1:0]     seq_ff, seq_in;
   logic [hbws_pkg::TICK_W-1:0]    posted_ff, posted_in;
   logic [hbws_pkg::TICK_W-1:0]    consumed_ff, consumed_in;
   logic [hbws_pkg::TICK_W-1:0]    healthy_ff, healthy_in;
   logic                           armed_ff, armed_in;
   logic                           active_ff, active_in;
   logic                           latched_ff, latched_in;
   logic [hbws_pkg::CNT_W-1:0]     beats_ff, beats_in;
   logic [hbws_pkg::CNT_W-1:0]     touts_ff, touts_in;
   hbws_pkg::reason_type           cause_ff, cause_in;

   // result register
   logic                           out_valid_ff, out_valid_in;
   hbws_pkg::rsp_item_type         out_ff, out_in;

   logic                           done;
   logic                           fired;
   hbws_pkg::reason_type           reason;
   logic [hbws_pkg::SEQ_W-1:0]     seq_next;
   logic [hbws_pkg::TICK_W-1:0]    elapsed;

   assign advance  = item_valid && (!out_valid_ff || rsp_ready);
   assign seq_next = seq_ff + 1'b1;

   // timeout register write, zero stored as one
   always_comb begin
      timeout_in = timeout_ff;
      if (csr_write) begin
         timeout_in = (csr_data == '0) ? hbws_pkg::TIMEOUT_MIN : csr_data;
      end
   end

   // item update
   always_comb begin
      seq_in      = seq_ff;
      posted_in   = posted_ff;
      consumed_in = consumed_ff;
      healthy_in  = healthy_ff;
      armed_in    = armed_ff;
      active_in   = active_ff;
      latched_in  = latched_ff;
      beats_in    = beats_ff;
      touts_in    = touts_ff;
      cause_in    = cause_ff;
      done        = 1'b0;
      fired       = 1'b0;
      reason      = hbws_pkg::REASON_NONE;
      elapsed     = '0;

      case (hbws_pkg::mode_type'(item.mode))
         hbws_pkg::MODE_POST: begin
            seq_in    = seq_next;
            posted_in = {seq_next, item.heartbeat_mode};
            done      = 1'b1;
         end
         hbws_pkg::MODE_TICK: begin
            // consume a changed mailbox word
            if (posted_ff != consumed_ff) begin
               consumed_in = posted_ff;
               if (posted_ff[0]) begin
                  healthy_in = item.tick_stamp;
                  beats_in   = beats_ff + 1'b1;
                  armed_in   = 1'b1;
                  active_in  = 1'b0;
               end else begin
                  armed_in = 1'b0;
                  cause_in = hbws_pkg::REASON_DISARMED;
                  fired    = 1'b1;
                  reason   = hbws_pkg::REASON_DISARMED;
               end
            end
            // elapsed time against the healthy stamp after any consume this tick
            elapsed = item.tick_stamp - healthy_in;
            // timeout check
            if (armed_in && (elapsed >= {1'b0, timeout_ff})) begin
               active_in  = 1'b1;
               latched_in = 1'b1;
               touts_in   = touts_ff + 1'b1;
               armed_in   = 1'b0;
               cause_in   = hbws_pkg::REASON_TIMEOUT;
               fired      = 1'b1;
               reason     = hbws_pkg::REASON_TIMEOUT;
            end
            done = fired;
         end
         hbws_pkg::MODE_CLEAR: begin
            if (!active_ff) begin
               latched_in = 1'b0;
               done       = 1'b1;
            end
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   // result built from the updated state
   always_comb begin
      out_in.done_res            = done;
      out_in.stop_fired          = fired;
      out_in.stop_reason         = reason;
      out_in.motion_permitted    = armed_in;
      out_in.timeout_active      = active_in;
      out_in.timeout_latched     = latched_in;
      out_in.accepted_heartbeats = beats_in;
      out_in.timeouts_seen       = touts_in;
      out_in.last_stop_reason    = cause_in;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= hbws_pkg::TIMEOUT_RESET;
         seq_ff       <= '0;
         posted_ff    <= '0;
         consumed_ff  <= '0;
         healthy_ff   <= '0;
         armed_ff     <= 1'b0;
         active_ff    <= 1'b0;
         latched_ff   <= 1'b0;
         beats_ff     <= '0;
         touts_ff     <= '0;
         cause_ff     <= hbws_pkg::REASON_BOOT;
         out_valid_ff <= 1'b0;
      end else begin
         timeout_ff   <= timeout_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            seq_ff      <= seq_in;
            posted_ff   <= posted_in;
            consumed_ff <= consumed_in;
            healthy_ff  <= healthy_in;
            armed_ff    <= armed_in;
            active_ff   <= active_in;
            latched_ff  <= latched_in;
            beats_ff    <= beats_in;
            touts_ff    <= touts_in;
            cause_ff    <= cause_in;
         end
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   // checks
   a_reason_only_on_stop: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.stop_fired) |-> (out_ff.stop_reason == hbws_pkg::REASON_NONE))
      else $error("stop reason without a stop");

   a_stop_disarms: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.stop_fired) |-> !out_ff.motion_permitted)
      else $error("motion permitted after a stop");

   a_active_latched: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> latched_ff)
      else $error("active timeout without latch");

   a_timeout_nonzero: assert property (@(posedge clock) disable iff (reset)
      timeout_ff != '0)
      else $error("timeout register is zero");

   a_armed_not_active: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> !active_ff)
      else $error("armed while a timeout is active");

endmodule

@@ design/heartbeat_watchdog_supervisor.sv @@
// ----------------------------------------------------------------------------
// heartbeat_watchdog_supervisor
// Heartbeat watchdog: mailbox posts, supervising ticks and latch clears.
// ----------------------------------------------------------------------------
//  channel    direction  payload
//  req_chan   in         mode, heartbeat_mode, tick_stamp
//  rsp_chan   out        done_res ... last_stop_reason, one item per request
//  csr_chan   in         timeout limit write data
//
//  An accepted request passes through the input register, then the update
//  logic and the result register. One item per cycle sustained while the
//  results are taken; the subtract and compare of the timeout check set the
//  stage length.
//  Reset is synchronous; the timeout limit returns to 1000, last stop reason boot.
//  A stalled result holds the core; the input register then fills and
//  req_chan.ready drops.
// ----------------------------------------------------------------------------
module heartbeat_watchdog_supervisor (
   input  logic        clock,
   input  logic        reset,
   hbws_req_if.sink    req_chan,
   hbws_rsp_if.source  rsp_chan,
   hbws_csr_if.sink    csr_chan
);

   hbws_pkg::req_item_type req_item;
   hbws_pkg::req_item_type item;
   hbws_pkg::rsp_item_type rsp_item;
   logic                   item_valid;
   logic                   advance;
   logic                   csr_write;

   assign req_item.mode           = req_chan.mode;
   assign req_item.heartbeat_mode = req_chan.heartbeat_mode;
   assign req_item.tick_stamp     = req_chan.tick_stamp;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;

   hbws_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   hbws_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .csr_write  (csr_write),
      .csr_data   (csr_chan.data),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_item   (rsp_item)
   );

   assign rsp_chan.done_res            = rsp_item.done_res;
   assign rsp_chan.stop_fired          = rsp_item.stop_fired;
   assign rsp_chan.stop_reason         = rsp_item.stop_reason;
   assign rsp_chan.motion_permitted    = rsp_item.motion_permitted;
   assign rsp_chan.timeout_active      = rsp_item.timeout_active;
   assign rsp_chan.timeout_latched     = rsp_item.timeout_latched;
   assign rsp_chan.accepted_heartbeats = rsp_item.accepted_heartbeats;
   assign rsp_chan.timeouts_seen       = rsp_item.timeouts_seen;
   assign rsp_chan.last_stop_reason    = rsp_item.last_stop_reason;

endmodule

@@ test/heartbeat_watchdog_supervisor_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_watchdog_supervisor_tb
// Drives posts, ticks, latch clears and unused item kinds into the watchdog
// under several timeout limits. A cycle-free model of the watchdog state
// predicts each status item. A monitor compares every result field with the
// oldest prediction. Random gaps, a long result stall and drain pauses add
// back-pressure.
// ----------------------------------------------------------------------------
module heartbeat_watchdog_supervisor_tb;

   logic clock;
   logic reset;

   hbws_req_if req_chan ();
   hbws_rsp_if rsp_chan ();
   hbws_csr_if csr_chan ();

   heartbeat_watchdog_supervisor i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // pending requests and predicted status items
   hbws_pkg::req_item_type pending_reqs[$];
   hbws_pkg::rsp_item_type expected_status[$];

   int unsigned gap_pct       = 37;
   int unsigned stall_asks    = 0;
   int unsigned stall_served  = 0;
   int unsigned stall_left    = 0;
   int unsigned error_count   = 0;
   int unsigned items_sent    = 0;
   int unsigned items_checked = 0;
   int unsigned timeout_stops = 0;
   int unsigned disarm_stops  = 0;
   logic [hbws_pkg::TICK_W-1:0] stim_clock;
   hbws_pkg::req_item_type      offered;

   // watchdog model state
   logic [hbws_pkg::TIMEOUT_W-1:0] timeout_limit;
   logic [hbws_pkg::SEQ_W-1:0]     seq_cnt;
   logic [31:0]                    post_word;
   logic [31:0]                    seen_word;
   logic [hbws_pkg::TICK_W-1:0]    beat_stamp;
   logic                           armed;
   logic                           active;
   logic                           latched;
   logic [hbws_pkg::CNT_W-1:0]     beat_count;
   logic [hbws_pkg::CNT_W-1:0]     timeout_count;
   hbws_pkg::reason_type           last_cause;

   function automatic void reset_watchdog_model();
      timeout_limit = hbws_pkg::TIMEOUT_RESET;
      seq_cnt       = '0;
      post_word     = '0;
      seen_word     = '0;
      beat_stamp    = '0;
      armed         = 1'b0;
      active        = 1'b0;
      latched       = 1'b0;
      beat_count    = '0;
      timeout_count = '0;
      last_cause    = hbws_pkg::REASON_BOOT;
   endfunction

   // a zero limit is stored as the minimum
   function automatic void set_timeout_limit(input logic [hbws_pkg::TIMEOUT_W-1:0] value);
      timeout_limit = (value == '0) ? hbws_pkg::TIMEOUT_MIN : value;
   endfunction

   // apply one request to the model and return the status it yields
   function automatic hbws_pkg::rsp_item_type step_watchdog(
      input hbws_pkg::req_item_type it);
      hbws_pkg::rsp_item_type      res;
      logic [hbws_pkg::TICK_W-1:0] elapsed;
      res = '0;
      case (it.mode)
         hbws_pkg::MODE_POST: begin
            seq_cnt      = seq_cnt + 1'b1;
            post_word    = {seq_cnt, it.heartbeat_mode};
            res.done_res = 1'b1;
         end
         hbws_pkg::MODE_TICK: begin
            if (post_word != seen_word) begin
               seen_word = post_word;
               if (post_word[0]) begin
                  beat_stamp = it.tick_stamp;
                  beat_count = beat_count + 1'b1;
                  armed      = 1'b1;
                  active     = 1'b0;
               end else begin
                  armed           = 1'b0;
                  last_cause      = hbws_pkg::REASON_DISARMED;
                  res.stop_fired  = 1'b1;
                  res.stop_reason = hbws_pkg::REASON_DISARMED;
               end
            end
            // wrapped elapsed time against the limit
            elapsed = it.tick_stamp - beat_stamp;
            if (armed && elapsed >= {1'b0, timeout_limit}) begin
               active          = 1'b1;
               latched         = 1'b1;
               timeout_count   = timeout_count + 1'b1;
               armed           = 1'b0;
               last_cause      = hbws_pkg::REASON_TIMEOUT;
               res.stop_fired  = 1'b1;
               res.stop_reason = hbws_pkg::REASON_TIMEOUT;
            end
            res.done_res = res.stop_fired;
         end
         hbws_pkg::MODE_CLEAR: begin
            if (!active) begin
               latched      = 1'b0;
               res.done_res = 1'b1;
            end
         end
         default: ;
      endcase
      res.motion_permitted    = armed;
      res.timeout_active      = active;
      res.timeout_latched     = latched;
      res.accepted_heartbeats = beat_count;
      res.timeouts_seen       = timeout_count;
      res.last_stop_reason    = last_cause;
      return res;
   endfunction

   // random item; ticks mostly advance a running time stamp
   function automatic hbws_pkg::req_item_type random_item(
      input logic [hbws_pkg::TIMEOUT_W-1:0] limit);
      hbws_pkg::req_item_type it;
      int unsigned pick;
      int unsigned span;
      pick              = $urandom_range(99);
      span              = (limit > 31'd2000) ? 4000 : 2 * limit + 2;
      it.heartbeat_mode = ($urandom_range(99) < 80);
      it.tick_stamp     = $urandom();
      if (pick < 24) begin
         it.mode = hbws_pkg::MODE_POST;
      end else if (pick < 76) begin
         it.mode       = hbws_pkg::MODE_TICK;
         stim_clock    = stim_clock + $urandom_range(span);
         it.tick_stamp = stim_clock;
      end else if (pick < 90) begin
         it.mode = hbws_pkg::MODE_CLEAR;
      end else if (pick < 95) begin
         it.mode = hbws_pkg::MODE_NONE;
      end else begin
         // jump anywhere, including backwards
         it.mode       = hbws_pkg::MODE_TICK;
         stim_clock    = $urandom();
         it.tick_stamp = stim_clock;
      end
      return it;
   endfunction

   function automatic void push_item(input hbws_pkg::mode_type m, input logic hb,
                                     input logic [hbws_pkg::TICK_W-1:0] stamp);
      hbws_pkg::req_item_type it;
      it.mode           = m;
      it.heartbeat_mode = hb;
      it.tick_stamp     = stamp;
      pending_reqs.push_back(it);
   endfunction

   function automatic void report_mismatch(input string field, input logic [31:0] want,
                                           input logic [31:0] got);
      $error("tb: field %s expected 0x%0h got 0x%0h", field, want, got);
      error_count++;
   endfunction

   // request driver: holds an offered item until it is taken
   always @(posedge clock) begin
      hbws_pkg::rsp_item_type want;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            want = step_watchdog(offered);
            expected_status.push_back(want);
            items_sent++;
            if (want.stop_reason == hbws_pkg::REASON_TIMEOUT) timeout_stops++;
            if (want.stop_reason == hbws_pkg::REASON_DISARMED) disarm_stops++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_reqs.size() != 0 && !($urandom_range(99) < gap_pct)) begin
               offered                  = pending_reqs.pop_front();
               req_chan.mode           <= offered.mode;
               req_chan.heartbeat_mode <= offered.heartbeat_mode;
               req_chan.tick_stamp     <= offered.tick_stamp;
               req_chan.valid          <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      hbws_pkg::rsp_item_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_status.size() == 0) begin
               $error("tb: status item with no prediction waiting");
               error_count++;
            end else begin
               want = expected_status.pop_front();
               items_checked++;
               if (rsp_chan.done_res !== want.done_res)
                  report_mismatch("done_res", 32'(want.done_res),
                                  32'(rsp_chan.done_res));
               if (rsp_chan.stop_fired !== want.stop_fired)
                  report_mismatch("stop_fired", 32'(want.stop_fired),
                                  32'(rsp_chan.stop_fired));
               if (rsp_chan.stop_reason !== want.stop_reason)
                  report_mismatch("stop_reason", 32'(want.stop_reason),
                                  32'(rsp_chan.stop_reason));
               if (rsp_chan.motion_permitted !== want.motion_permitted)
                  report_mismatch("motion_permitted", 32'(want.motion_permitted),
                                  32'(rsp_chan.motion_permitted));
               if (rsp_chan.timeout_active !== want.timeout_active)
                  report_mismatch("timeout_active", 32'(want.timeout_active),
                                  32'(rsp_chan.timeout_active));
               if (rsp_chan.timeout_latched !== want.timeout_latched)
                  report_mismatch("timeout_latched", 32'(want.timeout_latched),
                                  32'(rsp_chan.timeout_latched));
               if (rsp_chan.accepted_heartbeats !== want.accepted_heartbeats)
                  report_mismatch("accepted_heartbeats", want.accepted_heartbeats,
                                  rsp_chan.accepted_heartbeats);
               if (rsp_chan.timeouts_seen !== want.timeouts_seen)
                  report_mismatch("timeouts_seen", want.timeouts_seen,
                                  rsp_chan.timeouts_seen);
               if (rsp_chan.last_stop_reason !== want.last_stop_reason)
                  report_mismatch("last_stop_reason", 32'(want.last_stop_reason),
                                  32'(rsp_chan.last_stop_reason));
            end
         end
         // long hold-off on request, counted here
         if (stall_asks != stall_served) begin
            stall_served++;
            stall_left = 90;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !($urandom_range(99) < gap_pct);
         end
      end
   end

   // write the timeout register; called only while idle
   task automatic write_timeout(input logic [hbws_pkg::TIMEOUT_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      set_timeout_limit(value);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_status.size() != 0 || req_chan.valid)
         @(posedge clock);
   endtask

   task automatic run_random(input int unsigned count,
                             input logic [hbws_pkg::TIMEOUT_W-1:0] limit);
      for (int unsigned i = 0; i < count; i++)
         pending_reqs.push_back(random_item(limit));
   endtask

   // stimulus
   initial begin
      logic [hbws_pkg::TIMEOUT_W-1:0] mid_limit;
      clock                   = 1'b0;
      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.mode           = hbws_pkg::MODE_NONE;
      req_chan.heartbeat_mode = 1'b0;
      req_chan.tick_stamp     = '0;
      rsp_chan.ready          = 1'b0;
      csr_chan.valid          = 1'b0;
      csr_chan.data           = '0;
      stim_clock              = '0;
      reset_watchdog_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset limit: boot status, timeout across the time stamp wrap
      push_item(hbws_pkg::MODE_NONE, 1'b1, 32'hFFFF_FFFF);
      push_item(hbws_pkg::MODE_CLEAR, 1'b0, 32'h0);
      push_item(hbws_pkg::MODE_TICK, 1'b0, 32'h0);
      push_item(hbws_pkg::MODE_POST, 1'b1, 32'h0);
      push_item(hbws_pkg::MODE_TICK, 1'b0, 32'hFFFF_FF00);
      push_item(hbws_pkg::MODE_TICK, 1'b0, 32'hFFFF_FFFF);
      push_item(hbws_pkg::MODE_TICK, 1'b0, 32'h0000_02E7);
      push_item(hbws_pkg::MODE_TICK, 1'b0, 32'h0000_02E8);
      // clear while active keeps the latch
      push_item(hbws_pkg::MODE_CLEAR, 1'b0, 32'h0);
      push_item(hbws_pkg::MODE_POST, 1'b0, 32'h0);
      push_item(hbws_pkg::MODE_TICK, 1'b0, 32'h0000_0300);
      push_item(hbws_pkg::MODE_CLEAR, 1'b0, 32'h0);
      push_item(hbws_pkg::MODE_POST, 1'b1, 32'h0);
      push_item(hbws_pkg::MODE_TICK, 1'b0, 32'h0000_0400);
      push_item(hbws_pkg::MODE_CLEAR, 1'b0, 32'h0);
      // later post overwrites the mailbox before a tick
      push_item(hbws_pkg::MODE_POST, 1'b0, 32'h0);
      push_item(hbws_pkg::MODE_POST, 1'b1, 32'h0);
      push_item(hbws_pkg::MODE_TICK, 1'b0, 32'h0000_0500);
      push_item(hbws_pkg::MODE_POST, 1'b1, 32'h0);
      push_item(hbws_pkg::MODE_POST, 1'b0, 32'h0);
      push_item(hbws_pkg::MODE_TICK, 1'b1, 32'h0000_0600);
      push_item(hbws_pkg::MODE_TICK, 1'b1, 32'hFFFF_FFFF);
      wait_drained();

      // zero write stores the minimum limit
      write_timeout('0);
      push_item(hbws_pkg::MODE_POST, 1'b1, 32'h0);
      push_item(hbws_pkg::MODE_TICK, 1'b0, 32'h7);
      push_item(hbws_pkg::MODE_TICK, 1'b0, 32'h8);
      wait_drained();

      // largest limit
      write_timeout({hbws_pkg::TIMEOUT_W{1'b1}});
      push_item(hbws_pkg::MODE_POST, 1'b1, 32'h0);
      push_item(hbws_pkg::MODE_TICK, 1'b0, 32'h0);
      push_item(hbws_pkg::MODE_TICK, 1'b0, 32'h7FFF_FFFE);
      push_item(hbws_pkg::MODE_TICK, 1'b0, 32'h7FFF_FFFF);
      wait_drained();

      // random phases
      write_timeout(31'd17);
      run_random(150, 31'd17);
      wait_drained();

      // no gaps on either side
      gap_pct = 0;
      write_timeout(31'd1);
      run_random(80, 31'd1);
      wait_drained();
      gap_pct = 37;

      // receiver holds off while the sender keeps offering
      write_timeout(hbws_pkg::TIMEOUT_RESET);
      run_random(100, hbws_pkg::TIMEOUT_RESET);
      stall_asks++;
      wait_drained();

      mid_limit = 31'($urandom_range(300, 2));
      write_timeout(mid_limit);
      run_random(120, mid_limit);
      wait_drained();

      write_timeout({hbws_pkg::TIMEOUT_W{1'b1}});
      run_random(100, {hbws_pkg::TIMEOUT_W{1'b1}});
      wait_drained();

      repeat (8) @(posedge clock);
      $display("tb: %0d items sent, %0d checked, %0d timeout stops, %0d disarm stops",
               items_sent, items_checked, timeout_stops, disarm_stops);
      $display("tb: limits zero, 1, 17, reset, random and max; one long result stall");
      if (error_count == 0 && expected_status.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

@@ heartbeat_watchdog_supervisor.f @@
design/hbws_pkg.sv
design/hbws_if.sv
design/hbws_in_stage.sv
design/hbws_core.sv
design/heartbeat_watchdog_supervisor.sv
test/heartbeat_watchdog_supervisor_tb.sv
